@@ src/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg
// Types, codes and constants shared by the torus section tessellator.
// ----------------------------------------------------------------------------
package tst_pkg;

  // divider: dividend width and radix-4 step count
  localparam int DIV_W     = 26;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // CORDIC gain-compensated start value, Q1.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam int CORDIC_ITERS = 16;

  // input kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  // result kind codes
  localparam logic [1:0] OUT_VERTEX = 2'd0;
  localparam logic [1:0] OUT_TRI    = 2'd1;
  localparam logic [1:0] OUT_LAST   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_MAJOR_R  = 3'd3;
  localparam logic [2:0] REG_MINOR_R  = 3'd4;
  localparam logic [2:0] REG_START_A  = 3'd5;
  localparam logic [2:0] REG_END_A    = 3'd6;
  localparam logic [2:0] REG_SEGMENTS = 3'd7;

  typedef enum logic [1:0] {PH_IDLE, PH_VERT, PH_TRI, PH_DONE} phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MTH, ST_DTH, ST_DU, ST_CTH, ST_CPH, ST_MUL, ST_TRI, ST_EMIT
  } seq_state_t;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } div_req_t;

  // request to the shared CORDIC
  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cor_req_t;

  // arctangent table, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [3:0] k);
    logic [31:0] v;
    begin
      case (k)
        4'd0:    v = 32'h20000000;
        4'd1:    v = 32'h12E4051E;
        4'd2:    v = 32'h09FB385B;
        4'd3:    v = 32'h051111D4;
        4'd4:    v = 32'h028B0D43;
        4'd5:    v = 32'h0145D7E1;
        4'd6:    v = 32'h00A2F61E;
        4'd7:    v = 32'h00517C55;
        4'd8:    v = 32'h0028BE53;
        4'd9:    v = 32'h00145F2F;
        4'd10:   v = 32'h000A2F98;
        4'd11:   v = 32'h000517CC;
        4'd12:   v = 32'h00028BE6;
        4'd13:   v = 32'h000145F3;
        4'd14:   v = 32'h0000A2F9;
        default: v = 32'h0000517C;
      endcase
      return v;
    end
  endfunction

endpackage

@@ src/tst_if.sv @@
// ----------------------------------------------------------------------------
// tst_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface tst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] base_index;
  modport source (output valid, kind, base_index, input ready);
  modport sink   (input valid, kind, base_index, output ready);
endinterface

interface tst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_out;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] nrm_x;
  logic [15:0] nrm_y;
  logic [15:0] nrm_z;
  logic [15:0] tex_u;
  logic [15:0] tex_v;
  logic [31:0] idx_a;
  logic [31:0] idx_b;
  logic [31:0] idx_c;
  modport source (output valid, kind_out, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  tex_u, tex_v, idx_a, idx_b, idx_c, input ready);
  modport sink   (input valid, kind_out, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  tex_u, tex_v, idx_a, idx_b, idx_c, output ready);
endinterface

@@ src/tst_div.sv @@
// ----------------------------------------------------------------------------
// tst_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tst_div import tst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [7:0]        dsr_r, dsr_nxt;

  logic [8:0]       r1, r2, r1s, r2s;
  logic             b1, b2;
  logic [DIV_W-1:0] d1, d2;

  // two restoring steps
  always_comb begin
    r1  = {rem_r, dvd_r[DIV_W-1]};
    b1  = (r1 >= {1'b0, dsr_r});
    r1s = b1 ? (r1 - {1'b0, dsr_r}) : r1;
    d1  = {dvd_r[DIV_W-2:0], b1};
    r2  = {r1s[7:0], d1[DIV_W-1]};
    b2  = (r2 >= {1'b0, dsr_r});
    r2s = b2 ? (r2 - {1'b0, dsr_r}) : r2;
    d2  = {d1[DIV_W-2:0], b2};
  end

  // control and datapath next values
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      dvd_nxt = d2;
      rem_nxt = r2s[7:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ src/tst_cordic.sv @@
// ----------------------------------------------------------------------------
// tst_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with
// quadrant folding; returns Q1.14 cosine and sine.
// ----------------------------------------------------------------------------
module tst_cordic import tst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cor_req_t           req,
  output logic               done,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [3:0]         k_r, k_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic [1:0]         q_r, q_nxt;

  logic [31:0]        a_full, a_off;
  logic signed [33:0] dx, dy, cx, cy;

  // Q1.30 to Q1.14 with rounding and clamp
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    begin
      t = 35'(v) + 35'sd32768;
      r = 19'(t >>> 16);
      if (r > 19'sd16384)       r = 19'sd16384;
      else if (r < -19'sd16384) r = -19'sd16384;
      return r[15:0];
    end
  endfunction

  // micro-rotation and load
  always_comb begin
    a_full   = {req.angle, 16'b0};
    a_off    = a_full + 32'h2000_0000;
    dx       = y_r >>> k_r;
    dy       = x_r >>> k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      x_nxt    = CORDIC_K;
      y_nxt    = '0;
      q_nxt    = a_off[31:30];
      z_nxt    = $signed(a_full - {a_off[31:30], 30'b0});
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - $signed(atan_lut(k_r));
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + $signed(atan_lut(k_r));
      end
      k_nxt = k_r + 1'b1;
      if (k_r == 4'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // quadrant restore
  always_comb begin
    case (q_r)
      2'd0:    begin cx = x_r;  cy = y_r;  end
      2'd1:    begin cx = -y_r; cy = x_r;  end
      2'd2:    begin cx = -x_r; cy = -y_r; end
      default: begin cx = y_r;  cy = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    q_r <= q_nxt;
  end

  assign done  = done_r;
  assign cos_o = to_q14(cx);
  assign sin_o = to_q14(cy);

endmodule

@@ src/torus_section_tessellator_unit.sv @@
// ----------------------------------------------------------------------------
// torus_section_tessellator_unit
// Torus arc tessellator: vertices then triangle index triples, computed by
// a sequencer around one divider, one CORDIC and one multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | kind, base_index
//  out_ch  | out | valid/ready        | kind_out, pos, nrm, tex, idx_a/b/c
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
//  A vertex beat passes through the accept, one setup multiply, two divisions,
//  two CORDIC runs, fourteen multiply/accumulate steps and one emit step;
//  ring angle and v come from a constant table. A start beat ends at the accept.
//  A triangle beat passes through the accept, one index step and the emit step.
//  in_ch.ready is high only while the sequencer is idle; a finished result
//  waits in the output register while the next beat is taken.
//  Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module torus_section_tessellator_unit import tst_pkg::*; #(
  parameter int RING_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tst_in_if.sink      in_ch,
  tst_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int RW = $clog2(RING_STEPS + 1);
  localparam logic [RW-1:0] RS_W   = RW'(RING_STEPS);
  localparam logic [RW-1:0] RS_M1  = RW'(RING_STEPS - 1);
  localparam logic [31:0]   ROW    = 32'(RING_STEPS + 1);

  // configuration
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic [14:0]        rmaj_r, rmin_r;
  logic signed [17:0] sa_r, ea_r;
  logic [7:0]         seg_r;
  logic [7:0]         segs;

  // section state
  phase_t        phase_r, phase_nxt;
  logic [7:0]    sweep_r, sweep_nxt;
  logic [RW-1:0] ring_r, ring_nxt;
  logic          second_r, second_nxt;
  logic [31:0]   base_r, base_nxt;

  // sequencer
  seq_state_t seq_r, seq_nxt;
  logic       kick_r;
  logic [3:0] mstep_r, mstep_nxt;

  // working registers
  logic [7:0]         wi_r, wi_nxt;
  logic [RW-1:0]      wj_r, wj_nxt;
  logic               tri_r, tri_nxt;
  logic [1:0]         tkind_r, tkind_nxt;
  logic               tsec_r, tsec_nxt;
  logic signed [36:0] prod_r, prod_nxt;
  logic [15:0]        theta_r, theta_nxt, phi_r, phi_nxt;
  logic [15:0]        tu_r, tu_nxt, tv_r, tv_nxt;
  logic signed [15:0] ct_r, ct_nxt, st_r, st_nxt, cp_r, cp_nxt, sp_r, sp_nxt;
  logic signed [15:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [18:0] ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [31:0]        c_r, c_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_kind_r, o_kind_nxt;
  logic [15:0] o_px_r, o_px_nxt, o_py_r, o_py_nxt, o_pz_r, o_pz_nxt;
  logic [15:0] o_nx_r, o_nx_nxt, o_ny_r, o_ny_nxt, o_nz_r, o_nz_nxt;
  logic [15:0] o_u_r, o_u_nxt, o_v_r, o_v_nxt;
  logic [31:0] o_a_r, o_a_nxt, o_b_r, o_b_nxt, o_c_r, o_c_nxt;

  // shared units
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  cor_req_t           cor_req;
  logic               cor_done;
  logic signed [15:0] cor_c, cor_s;

  logic signed [19:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [36:0] mul_p;
  logic signed [36:0] rnd_full, mag;
  logic signed [18:0] rnd19;
  logic signed [18:0] diff;
  logic               accept, out_free, last_cell;
  logic [2:0]         op;
  logic [16:0]        phi_full;

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    logic [15:0] r;
    begin
      if (v > 19'sd32767)       r = 16'h7FFF;
      else if (v < -19'sd32768) r = 16'h8000;
      else                      r = v[15:0];
      return r;
    end
  endfunction

  // j * 65536 / RING_STEPS, one constant entry for each j from 0 to RING_STEPS
  function automatic logic [16:0] phi_lut(input logic [RW-1:0] j);
    logic [16:0] v;
    begin
      v = '0;
      for (int k = 0; k <= RING_STEPS; k++) begin
        if (j == RW'(k)) v = 17'((k * 65536) / RING_STEPS);
      end
      return v;
    end
  endfunction

  tst_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_q)
  );

  tst_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .req(cor_req), .done(cor_done),
    .cos_o(cor_c), .sin_o(cor_s)
  );

  assign segs      = (seg_r == 8'd0) ? 8'd1 : seg_r;
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign op        = mstep_r[3:1];
  assign diff      = 19'(ea_r) - 19'(sa_r);
  assign last_cell = (ring_r >= RS_M1) && (({1'b0, sweep_r} + 9'd1) >= {1'b0, segs});
  assign mul_p     = mul_a * mul_b;
  assign rnd_full  = (prod_r + 37'sd8192) >>> 14;
  assign rnd19     = rnd_full[18:0];
  assign mag       = prod_r[36] ? -prod_r : prod_r;
  assign phi_full  = phi_lut(wj_r);

  // next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      ST_IDLE: begin
        if (accept && in_ch.kind == KIND_NEXT) begin
          if (phase_r == PH_VERT)     seq_nxt = ST_MTH;
          else if (phase_r == PH_TRI) seq_nxt = ST_TRI;
        end
      end
      ST_MTH:  seq_nxt = ST_DTH;
      ST_DTH:  if (div_done) seq_nxt = ST_DU;
      ST_DU:   if (div_done) seq_nxt = ST_CTH;
      ST_CTH:  if (cor_done) seq_nxt = ST_CPH;
      ST_CPH:  if (cor_done) seq_nxt = ST_MUL;
      ST_MUL:  if (mstep_r == 4'd13) seq_nxt = ST_EMIT;
      ST_TRI:  seq_nxt = ST_EMIT;
      ST_EMIT: if (out_free) seq_nxt = ST_IDLE;
      default: seq_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: ready, unit requests, multiplier operands
  always_comb begin
    in_ch.ready      = (seq_r == ST_IDLE);
    div_req.start    = kick_r && (seq_r == ST_DTH || seq_r == ST_DU);
    div_req.dividend = mag[DIV_W-1:0];
    div_req.divisor  = segs;
    cor_req.start    = kick_r && (seq_r == ST_CTH || seq_r == ST_CPH);
    cor_req.angle    = theta_r;
    mul_a            = '0;
    mul_b            = '0;
    unique case (seq_r)
      ST_DU:  div_req.dividend = DIV_W'({wi_r, 15'b0});
      ST_CPH: cor_req.angle = phi_r;
      ST_MTH: begin
        mul_a = 20'(diff);
        mul_b = $signed({9'b0, wi_r});
      end
      ST_MUL: begin
        case (op)
          3'd0:    begin mul_a = 20'(ct_r); mul_b = 17'(cp_r); end
          3'd1:    begin mul_a = 20'(st_r); mul_b = 17'(cp_r); end
          3'd2:    begin mul_a = 20'(ct_r); mul_b = $signed({2'b0, rmaj_r}); end
          3'd3:    begin mul_a = 20'(st_r); mul_b = $signed({2'b0, rmaj_r}); end
          3'd4:    begin mul_a = 20'(nx_r); mul_b = $signed({2'b0, rmin_r}); end
          3'd5:    begin mul_a = 20'(ny_r); mul_b = $signed({2'b0, rmin_r}); end
          default: begin mul_a = 20'(sp_r); mul_b = $signed({2'b0, rmin_r}); end
        endcase
      end
      default: ;
    endcase
  end

  // section counters and datapath
  always_comb begin
    phase_nxt  = phase_r;
    sweep_nxt  = sweep_r;
    ring_nxt   = ring_r;
    second_nxt = second_r;
    base_nxt   = base_r;
    mstep_nxt  = mstep_r;
    wi_nxt     = wi_r;
    wj_nxt     = wj_r;
    tri_nxt    = tri_r;
    tkind_nxt  = tkind_r;
    tsec_nxt   = tsec_r;
    prod_nxt   = prod_r;
    theta_nxt  = theta_r;
    phi_nxt    = phi_r;
    tu_nxt     = tu_r;
    tv_nxt     = tv_r;
    ct_nxt     = ct_r;
    st_nxt     = st_r;
    cp_nxt     = cp_r;
    sp_nxt     = sp_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    az_nxt     = az_r;
    c_nxt      = c_r;

    // request beat: latch working step and advance the section
    if (accept) begin
      wi_nxt = sweep_r;
      wj_nxt = ring_r;
      if (in_ch.kind == KIND_START) begin
        base_nxt   = in_ch.base_index;
        phase_nxt  = PH_VERT;
        sweep_nxt  = '0;
        ring_nxt   = '0;
        second_nxt = 1'b0;
      end else if (phase_r == PH_VERT) begin
        tri_nxt   = 1'b0;
        mstep_nxt = '0;
        if (ring_r >= RS_W) begin
          ring_nxt = '0;
          if (sweep_r >= segs) begin
            phase_nxt  = PH_TRI;
            sweep_nxt  = '0;
            second_nxt = 1'b0;
          end else begin
            sweep_nxt = sweep_r + 8'd1;
          end
        end else begin
          ring_nxt = ring_r + 1'b1;
        end
      end else if (phase_r == PH_TRI) begin
        tri_nxt  = 1'b1;
        tsec_nxt = second_r;
        if (!second_r) begin
          tkind_nxt  = OUT_TRI;
          second_nxt = 1'b1;
        end else begin
          tkind_nxt  = last_cell ? OUT_LAST : OUT_TRI;
          second_nxt = 1'b0;
          if (last_cell) begin
            phase_nxt = PH_DONE;
            sweep_nxt = '0;
            ring_nxt  = '0;
          end else if (ring_r >= RS_M1) begin
            ring_nxt  = '0;
            sweep_nxt = sweep_r + 8'd1;
          end else begin
            ring_nxt = ring_r + 1'b1;
          end
        end
      end
    end

    case (seq_r)
      // sweep product, and ring angle and v from the table
      ST_MTH: begin
        prod_nxt = mul_p;
        phi_nxt  = phi_full[15:0];
        tv_nxt   = phi_full[16:1];
      end
      ST_DTH: if (div_done) begin
        theta_nxt = sa_r[15:0] + (prod_r[36] ? -div_q[15:0] : div_q[15:0]);
      end
      ST_DU:  if (div_done) tu_nxt = div_q[15:0];
      ST_CTH: if (cor_done) begin
        ct_nxt = cor_c;
        st_nxt = cor_s;
      end
      ST_CPH: if (cor_done) begin
        cp_nxt = cor_c;
        sp_nxt = cor_s;
      end
      // even step multiplies, odd step rounds and stores or accumulates
      ST_MUL: begin
        mstep_nxt = mstep_r + 4'd1;
        if (!mstep_r[0]) begin
          prod_nxt = mul_p;
        end else begin
          case (op)
            3'd0:    nx_nxt = rnd_full[15:0];
            3'd1:    ny_nxt = rnd_full[15:0];
            3'd2:    ax_nxt = 19'(cx_r) + rnd19;
            3'd3:    ay_nxt = 19'(cy_r) + rnd19;
            3'd4:    ax_nxt = ax_r + rnd19;
            3'd5:    ay_nxt = ay_r + rnd19;
            default: az_nxt = 19'(cz_r) + rnd19;
          endcase
        end
      end
      ST_TRI: c_nxt = base_r + 32'(wi_r) * ROW + 32'(wj_r);
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_kind_nxt    = o_kind_r;
    o_px_nxt      = o_px_r;
    o_py_nxt      = o_py_r;
    o_pz_nxt      = o_pz_r;
    o_nx_nxt      = o_nx_r;
    o_ny_nxt      = o_ny_r;
    o_nz_nxt      = o_nz_r;
    o_u_nxt       = o_u_r;
    o_v_nxt       = o_v_r;
    o_a_nxt       = o_a_r;
    o_b_nxt       = o_b_r;
    o_c_nxt       = o_c_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (seq_r == ST_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      if (tri_r) begin
        o_kind_nxt = tkind_r;
        o_px_nxt   = '0;
        o_py_nxt   = '0;
        o_pz_nxt   = '0;
        o_nx_nxt   = '0;
        o_ny_nxt   = '0;
        o_nz_nxt   = '0;
        o_u_nxt    = '0;
        o_v_nxt    = '0;
        o_b_nxt    = c_r + ROW;
        if (!tsec_r) begin
          o_a_nxt = c_r;
          o_c_nxt = c_r + 32'd1;
        end else begin
          o_a_nxt = c_r + 32'd1;
          o_c_nxt = c_r + ROW + 32'd1;
        end
      end else begin
        o_kind_nxt = OUT_VERTEX;
        o_px_nxt   = sat16(ax_r);
        o_py_nxt   = sat16(ay_r);
        o_pz_nxt   = sat16(az_r);
        o_nx_nxt   = nx_r;
        o_ny_nxt   = ny_r;
        o_nz_nxt   = sp_r;
        o_u_nxt    = tu_r;
        o_v_nxt    = tv_r;
        o_a_nxt    = '0;
        o_b_nxt    = '0;
        o_c_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      rmaj_r      <= 15'd2048;
      rmin_r      <= 15'd328;
      sa_r        <= '0;
      ea_r        <= 18'sd32768;
      seg_r       <= 8'd64;
      phase_r     <= PH_IDLE;
      sweep_r     <= '0;
      ring_r      <= '0;
      second_r    <= 1'b0;
      base_r      <= '0;
      seq_r       <= ST_IDLE;
      kick_r      <= 1'b0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER_X: cx_r   <= cfg_data[15:0];
          REG_CENTER_Y: cy_r   <= cfg_data[15:0];
          REG_CENTER_Z: cz_r   <= cfg_data[15:0];
          REG_MAJOR_R:  rmaj_r <= cfg_data[14:0];
          REG_MINOR_R:  rmin_r <= cfg_data[14:0];
          REG_START_A:  sa_r   <= cfg_data;
          REG_END_A:    ea_r   <= cfg_data;
          REG_SEGMENTS: seg_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      sweep_r     <= sweep_nxt;
      ring_r      <= ring_nxt;
      second_r    <= second_nxt;
      base_r      <= base_nxt;
      seq_r       <= seq_nxt;
      kick_r      <= (seq_nxt != seq_r);
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wi_r     <= wi_nxt;
    wj_r     <= wj_nxt;
    tri_r    <= tri_nxt;
    tkind_r  <= tkind_nxt;
    tsec_r   <= tsec_nxt;
    prod_r   <= prod_nxt;
    theta_r  <= theta_nxt;
    phi_r    <= phi_nxt;
    tu_r     <= tu_nxt;
    tv_r     <= tv_nxt;
    ct_r     <= ct_nxt;
    st_r     <= st_nxt;
    cp_r     <= cp_nxt;
    sp_r     <= sp_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    az_r     <= az_nxt;
    c_r      <= c_nxt;
    o_kind_r <= o_kind_nxt;
    o_px_r   <= o_px_nxt;
    o_py_r   <= o_py_nxt;
    o_pz_r   <= o_pz_nxt;
    o_nx_r   <= o_nx_nxt;
    o_ny_r   <= o_ny_nxt;
    o_nz_r   <= o_nz_nxt;
    o_u_r    <= o_u_nxt;
    o_v_r    <= o_v_nxt;
    o_a_r    <= o_a_nxt;
    o_b_r    <= o_b_nxt;
    o_c_r    <= o_c_nxt;
  end

  // result beat
  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind_out = o_kind_r;
  assign out_ch.pos_x    = o_px_r;
  assign out_ch.pos_y    = o_py_r;
  assign out_ch.pos_z    = o_pz_r;
  assign out_ch.nrm_x    = o_nx_r;
  assign out_ch.nrm_y    = o_ny_r;
  assign out_ch.nrm_z    = o_nz_r;
  assign out_ch.tex_u    = o_u_r;
  assign out_ch.tex_v    = o_v_r;
  assign out_ch.idx_a    = o_a_r;
  assign out_ch.idx_b    = o_b_r;
  assign out_ch.idx_c    = o_c_r;

endmodule

@@ tb/torus_section_tessellator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// torus_section_tessellator_unit_tb
// Self-checking bench for the torus section tessellator. Start and request
// beats go in with random burst gaps while the result side stalls on its own
// pattern. A built-in mesh predictor (CORDIC sine/cosine, saturated
// positions, index triples) works out each result, which is then compared
// with the result beats in order.
// ----------------------------------------------------------------------------
module torus_section_tessellator_unit_tb;
  import tst_pkg::*;

  localparam int RINGS      = 16;
  localparam int TAIL_CYC   = 200;
  localparam int STALL_LIM  = 3000;
  localparam int ITEM_GOAL  = 1250;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] px, py, pz, nx, ny, nz, tu, tv;
    logic [31:0] ia, ib, ic;
  } mesh_beat_t;

  localparam longint ARCTAN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  tst_in_if  in_ch ();
  tst_out_if out_ch ();

  torus_section_tessellator_unit #(.RING_STEPS(RINGS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and sequencer state
  logic signed [15:0] ctr_x, ctr_y, ctr_z;
  logic [14:0]        maj_rad, min_rad;
  logic signed [17:0] ang_start, ang_end;
  logic [7:0]         seg_reg;
  phase_t             mesh_phase;
  logic [7:0]         sweep_idx;
  logic [6:0]         ring_idx;
  logic               tri_second;
  logic [31:0]        vert_base;

  mesh_beat_t expected_beats[$];
  int items_sent, vert_seen, tri_seen, sections, cfg_writes;
  int mismatches;
  int burst_left;
  int idle_cyc;
  logic [15:0] stall_pat;
  logic [3:0]  stall_pos;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint round_q14(input longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic longint clamp_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic logic [15:0] sat_q12(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // CORDIC sine/cosine of a 16-bit angle, quadrant folded then restored
  function automatic void trig16(input logic [15:0] ang, output longint c,
                                 output longint s);
    logic [31:0] a;
    logic [31:0] qa;
    longint z, x, y, dx, dy, rx, ry;
    int q;
    a  = {ang, 16'h0000};
    qa = (a + 32'h20000000) >> 30;
    q  = qa[1:0];
    z  = longint'(a) - longint'(q) * 64'sh40000000;
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    x = 64'sd652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[k];
      end else begin
        x += dx; y -= dy; z += ARCTAN[k];
      end
    end
    case (q)
      0: begin rx = x;  ry = y;  end
      1: begin rx = -y; ry = x;  end
      2: begin rx = -x; ry = -y; end
      default: begin rx = y; ry = -x; end
    endcase
    c = clamp_q14(rx);
    s = clamp_q14(ry);
  endfunction

  function automatic int seg_eff();
    return (seg_reg == 8'd0) ? 1 : int'(seg_reg);
  endfunction

  // one vertex at the current sweep/ring position
  function automatic mesh_beat_t vertex_at();
    mesh_beat_t b;
    longint sa, ea, th, ct, st, cp, sp, nx, ny, nz, rr, mr;
    logic [15:0] theta, phi;
    int segs;
    segs = seg_eff();
    sa = longint'(ang_start);
    ea = longint'(ang_end);
    th = sa + (longint'(sweep_idx) * (ea - sa)) / segs;
    theta = th[15:0];
    phi = 16'((longint'(ring_idx) * 65536) / RINGS);
    rr = longint'(maj_rad);
    mr = longint'(min_rad);
    trig16(theta, ct, st);
    trig16(phi, cp, sp);
    nx = round_q14(ct * cp);
    ny = round_q14(st * cp);
    nz = sp;
    b = '0;
    b.kind = OUT_VERTEX;
    b.px = sat_q12(longint'(ctr_x) + round_q14(ct * rr) + round_q14(nx * mr));
    b.py = sat_q12(longint'(ctr_y) + round_q14(st * rr) + round_q14(ny * mr));
    b.pz = sat_q12(longint'(ctr_z) + round_q14(nz * mr));
    b.nx = nx[15:0];
    b.ny = ny[15:0];
    b.nz = nz[15:0];
    b.tu = 16'((longint'(sweep_idx) * 32768) / segs);
    b.tv = 16'((longint'(ring_idx) * 32768) / RINGS);
    return b;
  endfunction

  // advance the mesh sequencer by one beat; returns 1 when a result is due
  function automatic bit mesh_advance(input logic k, input logic [31:0] base,
                                      output mesh_beat_t b);
    logic [31:0] c, n;
    bit last_cell;
    int segs;
    segs = seg_eff();
    b = '0;
    if (k == KIND_START) begin
      vert_base = base;
      mesh_phase = PH_VERT;
      sweep_idx = 0; ring_idx = 0; tri_second = 0;
      return 0;
    end
    if (mesh_phase == PH_VERT) begin
      b = vertex_at();
      if (ring_idx >= RINGS) begin
        ring_idx = 0;
        if (sweep_idx >= segs) begin
          mesh_phase = PH_TRI; sweep_idx = 0; tri_second = 0;
        end else begin
          sweep_idx++;
        end
      end else begin
        ring_idx++;
      end
      return 1;
    end
    if (mesh_phase == PH_TRI) begin
      c = vert_base + 32'(sweep_idx) * 32'(RINGS + 1) + 32'(ring_idx);
      n = c + 32'(RINGS + 1);
      last_cell = (ring_idx >= RINGS - 1) && (int'(sweep_idx) + 1 >= segs);
      if (!tri_second) begin
        b.kind = OUT_TRI;
        b.ia = c; b.ib = n; b.ic = c + 1;
        tri_second = 1;
      end else begin
        b.kind = last_cell ? OUT_LAST : OUT_TRI;
        b.ia = c + 1; b.ib = n; b.ic = n + 1;
        tri_second = 0;
        if (last_cell) begin
          mesh_phase = PH_DONE; sweep_idx = 0; ring_idx = 0;
        end else if (ring_idx >= RINGS - 1) begin
          ring_idx = 0;
          sweep_idx++;
        end else begin
          ring_idx++;
        end
      end
      return 1;
    end
    return 0;
  endfunction

  // result side: stall pattern, reloaded each time the bit position wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_pos <= '0;
      stall_pat <= 16'hFFFF;
      out_ch.ready <= 1'b0;
    end else begin
      stall_pos <= stall_pos + 4'd1;
      if (stall_pos == 4'd15) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'hFFFF;
          1: stall_pat <= 16'($urandom | $urandom);
          default: stall_pat <= 16'($urandom);
        endcase
      end
      out_ch.ready <= stall_pat[stall_pos];
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    mesh_beat_t got, exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.kind_out;
      got.px = out_ch.pos_x; got.py = out_ch.pos_y; got.pz = out_ch.pos_z;
      got.nx = out_ch.nrm_x; got.ny = out_ch.nrm_y; got.nz = out_ch.nrm_z;
      got.tu = out_ch.tex_u; got.tv = out_ch.tex_v;
      got.ia = out_ch.idx_a; got.ib = out_ch.idx_b; got.ic = out_ch.idx_c;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        exp_b = expected_beats.pop_front();
        if (got.kind == OUT_VERTEX) vert_seen++;
        else tri_seen++;
        if (got.kind !== exp_b.kind || got.px !== exp_b.px || got.py !== exp_b.py ||
            got.pz !== exp_b.pz || got.nx !== exp_b.nx || got.ny !== exp_b.ny ||
            got.nz !== exp_b.nz || got.tu !== exp_b.tu || got.tv !== exp_b.tv ||
            got.ia !== exp_b.ia || got.ib !== exp_b.ib || got.ic !== exp_b.ic) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch\n  expected %p\n  actual   %p", exp_b, got);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
    if (idle_cyc >= STALL_LIM) begin
      $display("watchdog expired with %0d results outstanding", expected_beats.size());
      $display("simulation failed");
      $finish;
    end
  end

  // send one beat, with burst gaps on the request side
  task automatic send_beat(input logic k, input logic [31:0] base);
    mesh_beat_t e;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.base_index <= base;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
    if (k == KIND_START) sections++;
    if (mesh_advance(k, base, e)) expected_beats.insert(expected_beats.size(), e);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_CENTER_X: ctr_x = val[15:0];
      REG_CENTER_Y: ctr_y = val[15:0];
      REG_CENTER_Z: ctr_z = val[15:0];
      REG_MAJOR_R:  maj_rad = val[14:0];
      REG_MINOR_R:  min_rad = val[14:0];
      REG_START_A:  ang_start = val;
      REG_END_A:    ang_end = val;
      default:      seg_reg = val[7:0];
    endcase
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic section_requests(input int n);
    repeat (n) send_beat(KIND_NEXT, $urandom);
  endtask

  function automatic int section_len();
    return (seg_eff() + 1) * (RINGS + 1) + seg_eff() * RINGS * 2;
  endfunction

  // reset values, requests while idle, restart mid-section
  task automatic test_reset_defaults();
    section_requests(3);
    send_beat(KIND_START, 32'hFFFF_FFF0);
    section_requests(60);
    send_beat(KIND_START, $urandom);
    section_requests(12);
    drain();
  endtask

  // register extremes, zero segments, index wrap, requests after the end
  task automatic test_extremes();
    set_reg(REG_CENTER_X, 18'h07FFF);
    set_reg(REG_CENTER_Y, 18'h08000);
    set_reg(REG_CENTER_Z, 18'h07FFF);
    set_reg(REG_MAJOR_R, 18'h07FFF);
    set_reg(REG_MINOR_R, 18'h07FFF);
    set_reg(REG_START_A, 18'h20000);
    set_reg(REG_END_A, 18'h1FFFF);
    set_reg(REG_SEGMENTS, 18'h0);
    send_beat(KIND_START, 32'hFFFF_FFF8);
    section_requests(section_len() + 3);
    drain();
    set_reg(REG_CENTER_X, 18'h08000);
    set_reg(REG_CENTER_Y, 18'h07FFF);
    set_reg(REG_CENTER_Z, 18'h08000);
    set_reg(REG_MAJOR_R, 18'h0);
    set_reg(REG_MINOR_R, 18'h0);
    set_reg(REG_START_A, 18'h1FFFF);
    set_reg(REG_END_A, 18'h20000);
    set_reg(REG_SEGMENTS, 18'd1);
    send_beat(KIND_START, 32'h0);
    section_requests(section_len() + 2);
    drain();
  endtask

  // widest sweep count, cut short by a restart
  task automatic test_long_sweep();
    set_reg(REG_SEGMENTS, 18'd255);
    set_reg(REG_START_A, 18'h0);
    set_reg(REG_END_A, 18'h0FFFF);
    set_reg(REG_MAJOR_R, 18'd6000);
    set_reg(REG_MINOR_R, 18'd1500);
    send_beat(KIND_START, $urandom);
    section_requests(150);
    send_beat(KIND_START, $urandom);
    section_requests(20);
    drain();
  endtask

  // random settings and sections, some broken or noisy
  task automatic test_random_sections();
    int len, mode;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 1)) set_reg(REG_CENTER_X, 18'($urandom));
      if ($urandom_range(0, 1)) set_reg(REG_CENTER_Y, 18'($urandom));
      if ($urandom_range(0, 1)) set_reg(REG_CENTER_Z, 18'($urandom));
      if ($urandom_range(0, 1))
        set_reg(REG_MAJOR_R,
                18'($urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom));
      if ($urandom_range(0, 1))
        set_reg(REG_MINOR_R,
                18'($urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom));
      if ($urandom_range(0, 1)) set_reg(REG_START_A, 18'($urandom));
      if ($urandom_range(0, 1)) set_reg(REG_END_A, 18'($urandom));
      set_reg(REG_SEGMENTS, 18'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
                                                             : $urandom_range(1, 3)));
      len = section_len();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        // noise: random kinds
        repeat ($urandom_range(5, 30))
          send_beat($urandom_range(0, 4) == 0 ? KIND_START : KIND_NEXT, $urandom);
      end else if (mode == 1) begin
        // broken: restart part way through
        send_beat(KIND_START, $urandom);
        section_requests($urandom_range(1, len));
        send_beat(KIND_START, $urandom);
        section_requests(len);
      end else begin
        send_beat(KIND_START, $urandom);
        section_requests(len + $urandom_range(0, 3));
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_NEXT;
    in_ch.base_index <= '0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    maj_rad = 15'd2048; min_rad = 15'd328;
    ang_start = 0; ang_end = 18'sd32768; seg_reg = 8'd64;
    mesh_phase = PH_IDLE; sweep_idx = 0; ring_idx = 0; tri_second = 0;
    vert_base = 0;
    items_sent = 0; vert_seen = 0; tri_seen = 0; sections = 0; cfg_writes = 0;
    mismatches = 0; burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_long_sweep();
    test_random_sections();

    $display("covered %0d beats in %0d sections, %0d register writes",
             items_sent, sections, cfg_writes);
    $display("checked %0d vertices and %0d triangles, %0d mismatches",
             vert_seen, tri_seen, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
